/* src/ocf_pkg.sv */
// Package with the request and response types, codes and the knob scaling function.
`default_nettype none

package ocf_pkg;

   localparam logic [2:0] PH_SETUP  = 3'd0;
   localparam logic [2:0] PH_SELECT = 3'd1;
   localparam logic [2:0] PH_COOK   = 3'd2;
   localparam logic [2:0] PH_RESET  = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   localparam logic [1:0] MODE_BAKE  = 2'd0;
   localparam logic [1:0] MODE_TOAST = 2'd1;
   localparam logic [1:0] MODE_BROIL = 2'd2;

   localparam logic [1:0] FUNC_KNOB = 2'd0;

   localparam logic [16:0] STAMP_MOD     = 17'd100000;
   localparam logic [9:0]  TEMP_BASE     = 10'd300;
   localparam logic [9:0]  TEMP_BROIL    = 10'd500;
   localparam logic [7:0]  LONG_PRESS_RST = 8'd2;
   localparam logic [9:0]  TEMP_RST      = 10'd300;

   typedef struct packed {
      logic [1:0]  func;
      logic        btn3_down;
      logic        btn3_up;
      logic        btn4_down;
      logic        btn4_up;
      logic [9:0]  knob_value;
      logic [16:0] now_ticks;
   } req_type;

   typedef struct packed {
      logic [2:0]  oven_phase;
      logic [1:0]  mode;
      logic        editing_temp;
      logic [8:0]  set_seconds;
      logic [8:0]  left_seconds;
      logic [9:0]  temperature;
      logic [7:0]  led_bar;
      logic        display_inverted;
   } rsp_type;

   // Knob reading scaled to 0..255 through a percent-per-mille step, truncating twice.
   // The first division by 1023 is rewritten as k - ceil(23k / 1023).
   // The second division by 1000 is a shift by three and a reciprocal multiply for 125.
   function automatic logic [7:0] knob_level(input logic [9:0] knob);
      logic [14:0] prod23;
      logic [14:0] sum23;
      logic [4:0]  quo0;
      logic [10:0] rem0;
      logic [4:0]  ceil_q;
      logic [9:0]  pct;
      logic [17:0] scaled;
      logic [30:0] recip;
      prod23 = 15'(knob) * 15'd23;
      sum23  = prod23 + 15'd1022;
      quo0   = sum23[14:10];
      rem0   = {1'b0, sum23[9:0]} + 11'(quo0);
      ceil_q = (rem0 >= 11'd1023) ? quo0 + 5'd1 : quo0;
      pct    = knob - 10'(ceil_q);
      scaled = ({pct, 8'd0}) - 18'(pct);
      recip  = 31'(scaled[17:3]) * 31'd33555;
      return recip[29:22];
   endfunction

endpackage

`default_nettype wire

/* src/oven_control_fsm_top.sv */
// Toaster-oven controller: input register, single-pass state update and result register.
//
// The req_ channel carries one event per request (kind, button edges, knob reading and
// a 5 Hz timestamp). For every accepted request the block returns exactly one
// response on the rsp_ channel, a snapshot of the controller after the event.
// The csr_ channel writes the long-press threshold; csr_ready is always high.
// A request is taken into an input register; when the response register can advance,
// the controller state is updated by a single pass of logic and the snapshot is loaded
// into the response register, which drives rsp_valid and rsp_data.
// One request is accepted in every cycle while the response side keeps up.
// When rsp_stall is high and a response is held, the response register keeps its data, and the input register
// holds the pending request; req_stall rises only when both are occupied.
// Synchronous reset returns the controller to setup in bake mode, time editing,
// temperature 300, all counts and the LED bar at zero, threshold two ticks,
// and empties both registers.
`default_nettype none

module oven_control_fsm_top
   import ocf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic [7:0] csr_data
);

   logic        in_valid_ff, in_valid_in;
   req_type     in_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [7:0]  long_press_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  mode_ff, mode_in;
   logic        edit_temp_ff, edit_temp_in;
   logic [8:0]  cook_ff, cook_in;
   logic [8:0]  remain_ff, remain_in;
   logic [9:0]  temp_ff, temp_in;
   logic [16:0] press3_ff, press3_in;
   logic [16:0] press4_ff, press4_in;
   logic [7:0]  led_ff, led_in;
   logic [5:0]  led_step_ff, led_step_in;
   logic [5:0]  led_count_ff, led_count_in;
   logic        invert_ff, invert_in;

   logic        advance;
   logic        work;
   logic        run;
   logic [16:0] now_mod;
   logic [17:0] diff3, diff4;
   logic [16:0] elapsed3, elapsed4;
   logic        long3, long4;
   logic [7:0]  level;
   logic [5:0]  count_inc;
   logic [1:0]  mode_next;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign work      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign now_mod  = (in_data_ff.now_ticks >= STAMP_MOD) ?
                     in_data_ff.now_ticks - STAMP_MOD : in_data_ff.now_ticks;
   assign diff3    = {1'b0, now_mod} - {1'b0, press3_ff};
   assign diff4    = {1'b0, now_mod} - {1'b0, press4_ff};
   assign elapsed3 = diff3[17] ? 17'(diff3 + 18'(STAMP_MOD)) : diff3[16:0];
   assign elapsed4 = diff4[17] ? 17'(diff4 + 18'(STAMP_MOD)) : diff4[16:0];
   assign long3    = elapsed3 >= 17'(long_press_ff);
   assign long4    = elapsed4 >= 17'(long_press_ff);
   assign level    = knob_level(in_data_ff.knob_value);
   assign count_inc = led_count_ff + 6'd1;
   assign run      = !(in_data_ff.func == FUNC_KNOB &&
                       (phase_ff == PH_COOK || phase_ff == PH_DONE));

   always_comb begin
      unique case (mode_ff)
         MODE_BAKE:  mode_next = MODE_TOAST;
         MODE_TOAST: mode_next = MODE_BROIL;
         default:    mode_next = MODE_BAKE;
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      mode_in      = mode_ff;
      edit_temp_in = edit_temp_ff;
      cook_in      = cook_ff;
      remain_in    = remain_ff;
      temp_in      = temp_ff;
      press3_in    = press3_ff;
      press4_in    = press4_ff;
      led_in       = led_ff;
      led_step_in  = led_step_ff;
      led_count_in = led_count_ff;
      invert_in    = invert_ff;
      if (run) begin
         unique case (phase_ff) inside
            PH_SETUP: begin
               if (!edit_temp_ff) begin
                  cook_in = {1'b0, level} + 9'd1;
               end else begin
                  temp_in = {2'b00, level} + TEMP_BASE;
               end
               if (mode_ff == MODE_BROIL) begin
                  temp_in = TEMP_BROIL;
               end
               if (in_data_ff.btn3_down) begin
                  press3_in = now_mod;
                  phase_in  = PH_SELECT;
               end
               if (in_data_ff.btn4_down) begin
                  remain_in    = cook_in;
                  phase_in     = PH_COOK;
                  led_step_in  = cook_in[8:3];
                  led_count_in = 6'd0;
                  led_in       = 8'hFF;
               end
            end
            PH_SELECT: begin
               if (in_data_ff.btn3_up) begin
                  if (!long3) begin
                     mode_in      = mode_next;
                     edit_temp_in = 1'b0;
                     if (mode_next == MODE_BROIL) begin
                        temp_in = TEMP_BROIL;
                     end
                  end else if (mode_ff == MODE_BAKE) begin
                     edit_temp_in = !edit_temp_ff;
                  end else begin
                     edit_temp_in = 1'b0;
                  end
                  phase_in = PH_SETUP;
               end
            end
            PH_COOK, PH_RESET: begin
               if (phase_ff == PH_COOK &&
                   (in_data_ff.btn3_down || in_data_ff.btn3_up || in_data_ff.btn4_up)) begin
                  phase_in = phase_ff;
               end else if (phase_ff == PH_COOK && in_data_ff.btn4_down) begin
                  press4_in = now_mod;
                  phase_in  = PH_RESET;
               end else if (phase_ff == PH_RESET && long4) begin
                  phase_in = PH_SETUP;
                  led_in   = 8'd0;
               end else if (phase_ff == PH_RESET && in_data_ff.btn4_up) begin
                  phase_in = PH_COOK;
               end else if (remain_ff != 9'd0) begin
                  remain_in = remain_ff - 9'd1;
                  if (count_inc == led_step_ff) begin
                     led_count_in = 6'd0;
                     led_in       = {1'b0, led_ff[7:1]};
                  end else begin
                     led_count_in = count_inc;
                  end
               end else begin
                  remain_in = cook_ff;
                  phase_in  = PH_DONE;
                  led_in    = 8'd0;
                  if (phase_ff == PH_RESET) begin
                     invert_in = 1'b1;
                  end
               end
            end
            PH_DONE: begin
               if (in_data_ff.btn3_down || in_data_ff.btn3_up) begin
                  phase_in = phase_ff;
               end else if (in_data_ff.btn4_down) begin
                  phase_in  = PH_SETUP;
                  invert_in = 1'b0;
               end else begin
                  invert_in = !invert_ff;
               end
            end
            default: begin
               phase_in = PH_SETUP;
            end
         endcase
      end
   end

   always_comb begin
      rsp_data_in.oven_phase       = phase_in;
      rsp_data_in.mode             = mode_in;
      rsp_data_in.editing_temp     = edit_temp_in;
      rsp_data_in.set_seconds      = cook_in;
      rsp_data_in.left_seconds     = remain_in;
      rsp_data_in.temperature      = temp_in;
      rsp_data_in.led_bar          = led_in;
      rsp_data_in.display_inverted = invert_in;
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (work) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         long_press_ff <= LONG_PRESS_RST;
         phase_ff      <= PH_SETUP;
         mode_ff       <= MODE_BAKE;
         edit_temp_ff  <= 1'b0;
         cook_ff       <= 9'd0;
         remain_ff     <= 9'd0;
         temp_ff       <= TEMP_RST;
         press3_ff     <= 17'd0;
         press4_ff     <= 17'd0;
         led_ff        <= 8'd0;
         led_step_ff   <= 6'd0;
         led_count_ff  <= 6'd0;
         invert_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            long_press_ff <= csr_data;
         end
         if (work) begin
            phase_ff     <= phase_in;
            mode_ff      <= mode_in;
            edit_temp_ff <= edit_temp_in;
            cook_ff      <= cook_in;
            remain_ff    <= remain_in;
            temp_ff      <= temp_in;
            press3_ff    <= press3_in;
            press4_ff    <= press4_in;
            led_ff       <= led_in;
            led_step_ff  <= led_step_in;
            led_count_ff <= led_count_in;
            invert_ff    <= invert_in;
         end
      end
   end

endmodule

`default_nettype wire

/* verif/oven_control_fsm_top_tb.sv */
// Self-checking testbench for the toaster-oven controller with a built-in predictor.
`default_nettype none

module oven_control_fsm_top_tb;
   import ocf_pkg::*;

   localparam logic [1:0] FUNC_BUTTON = 2'd1;
   localparam logic [1:0] FUNC_SECOND = 2'd2;
   localparam logic [1:0] FUNC_BLINK  = 2'd3;

   localparam logic [3:0] BTN_NONE = 4'b0000;
   localparam logic [3:0] BTN_3D   = 4'b1000;
   localparam logic [3:0] BTN_3U   = 4'b0100;
   localparam logic [3:0] BTN_4D   = 4'b0010;
   localparam logic [3:0] BTN_4U   = 4'b0001;

   localparam int unsigned TICK_WRAP       = 100000;
   localparam int unsigned QUIET_LIMIT     = 2000;
   localparam int unsigned EVENTS_PER_STEP = 360;

   typedef struct {
      req_type ev;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data  = '0;

   // Predicted controller state.
   logic [7:0]  lp_ticks   = LONG_PRESS_RST;
   logic [2:0]  ph_q       = PH_SETUP;
   logic [1:0]  mode_q     = MODE_BAKE;
   logic        edit_q     = 1'b0;
   logic [8:0]  set_q      = '0;
   logic [8:0]  left_q     = '0;
   logic [9:0]  temp_q     = TEMP_RST;
   logic [16:0] b3_stamp   = '0;
   logic [16:0] b4_stamp   = '0;
   logic [7:0]  bar_q      = '0;
   logic [5:0]  step_q     = '0;
   logic [5:0]  cnt_q      = '0;
   logic        inv_q      = 1'b0;

   rsp_type      snapshot_q[$];
   dir_row_type  directed_events[$];
   int unsigned  stamp_now    = 0;
   int unsigned  mismatches   = 0;
   int unsigned  quiet_cycles = 0;
   bit           calm         = 1'b0;

   oven_control_fsm_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   function automatic int unsigned ticks_since(input int unsigned now, input int unsigned stamp);
      return (now + TICK_WRAP - stamp) % TICK_WRAP;
   endfunction

   function automatic void tick_second(input bit invert_on_done);
      if (left_q != 0) begin
         left_q = left_q - 9'd1;
         cnt_q  = cnt_q + 6'd1;
         if (cnt_q == step_q) begin
            cnt_q = '0;
            bar_q = bar_q >> 1;
         end
      end else begin
         left_q = set_q;
         ph_q   = PH_DONE;
         bar_q  = '0;
         if (invert_on_done)
            inv_q = 1'b1;
      end
   endfunction

   function automatic rsp_type oven_step(input req_type ev);
      int unsigned now_r;
      int unsigned pct;
      int unsigned level;
      rsp_type     snap;
      now_r = ev.now_ticks % TICK_WRAP;
      if (!(ev.func == FUNC_KNOB && (ph_q == PH_COOK || ph_q == PH_DONE))) begin
         case (ph_q)
            PH_SETUP: begin
               pct   = int'(ev.knob_value) * 1000 / 1023;
               level = pct * 255 / 1000;
               if (!edit_q)
                  set_q = 9'(level + 1);
               else
                  temp_q = 10'(level + 300);
               if (mode_q == MODE_BROIL)
                  temp_q = TEMP_BROIL;
               if (ev.btn3_down) begin
                  b3_stamp = 17'(now_r);
                  ph_q     = PH_SELECT;
               end
               if (ev.btn4_down) begin
                  left_q = set_q;
                  ph_q   = PH_COOK;
                  step_q = 6'(set_q / 8);
                  cnt_q  = '0;
                  bar_q  = 8'hFF;
               end
            end
            PH_SELECT: begin
               if (ev.btn3_up) begin
                  if (ticks_since(now_r, b3_stamp) < lp_ticks) begin
                     case (mode_q)
                        MODE_BAKE:  mode_q = MODE_TOAST;
                        MODE_TOAST: mode_q = MODE_BROIL;
                        default:    mode_q = MODE_BAKE;
                     endcase
                     edit_q = 1'b0;
                     if (mode_q == MODE_BROIL)
                        temp_q = TEMP_BROIL;
                  end else if (mode_q == MODE_BAKE) begin
                     edit_q = ~edit_q;
                  end else begin
                     edit_q = 1'b0;
                  end
                  ph_q = PH_SETUP;
               end
            end
            PH_COOK: begin
               if (!(ev.btn3_down || ev.btn3_up || ev.btn4_up)) begin
                  if (ev.btn4_down) begin
                     b4_stamp = 17'(now_r);
                     ph_q     = PH_RESET;
                  end else begin
                     tick_second(1'b0);
                  end
               end
            end
            PH_RESET: begin
               if (ticks_since(now_r, b4_stamp) >= lp_ticks) begin
                  ph_q  = PH_SETUP;
                  bar_q = '0;
               end else if (ev.btn4_up) begin
                  ph_q = PH_COOK;
               end else begin
                  tick_second(1'b1);
               end
            end
            PH_DONE: begin
               if (!(ev.btn3_down || ev.btn3_up)) begin
                  if (ev.btn4_down) begin
                     ph_q  = PH_SETUP;
                     inv_q = 1'b0;
                  end else begin
                     inv_q = ~inv_q;
                  end
               end
            end
            default: ph_q = PH_SETUP;
         endcase
      end
      snap.oven_phase       = ph_q;
      snap.mode             = mode_q;
      snap.editing_temp     = edit_q;
      snap.set_seconds      = set_q;
      snap.left_seconds     = left_q;
      snap.temperature      = temp_q;
      snap.led_bar          = bar_q;
      snap.display_inverted = inv_q;
      return snap;
   endfunction

   // Well-formed press and cook sequences chosen from the predicted phase, plus noise.
   function automatic req_type next_event();
      req_type     ev;
      int unsigned p;
      int unsigned dur;
      bit          noisy;
      ev    = '0;
      noisy = 1'b0;
      p     = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3)
         stamp_now = $urandom_range(0, TICK_WRAP - 1);
      else
         stamp_now = (stamp_now + $urandom_range(0, 2)) % TICK_WRAP;
      ev.knob_value = ($urandom_range(0, 99) < 70) ? 10'($urandom_range(0, 160)) : 10'($urandom);
      ev.func = FUNC_BUTTON;
      case (ph_q)
         PH_SETUP: begin
            if (p < 40)
               ev.func = FUNC_KNOB;
            else if (p < 65)
               ev.btn3_down = 1'b1;
            else if (p < 85)
               ev.btn4_down = 1'b1;
            else if (p < 90)
               {ev.btn3_down, ev.btn4_down} = 2'b11;
            else
               noisy = 1'b1;
         end
         PH_SELECT: begin
            if (p < 65) begin
               ev.btn3_up = 1'b1;
               dur        = $urandom_range(0, int'(lp_ticks) + 2);
               stamp_now  = (int'(b3_stamp) + dur) % TICK_WRAP;
            end else begin
               noisy = 1'b1;
            end
         end
         PH_COOK: begin
            if (p < 85)
               ev.func = 2'($urandom);
            else if (p < 87)
               ev.btn4_down = 1'b1;
            else
               noisy = 1'b1;
         end
         PH_RESET: begin
            if (p < 40) begin
               ev.func   = 2'($urandom);
               dur       = $urandom_range(0, int'(lp_ticks) + 2);
               stamp_now = (int'(b4_stamp) + dur) % TICK_WRAP;
            end else if (p < 70) begin
               ev.btn4_up = 1'b1;
               dur        = $urandom_range(0, int'(lp_ticks) + 1);
               stamp_now  = (int'(b4_stamp) + dur) % TICK_WRAP;
            end else begin
               noisy = 1'b1;
            end
         end
         default: begin
            if (p < 60)
               ev.func = ($urandom_range(0, 1) != 0) ? FUNC_BLINK : FUNC_SECOND;
            else if (p < 80)
               ev.btn4_down = 1'b1;
            else
               noisy = 1'b1;
         end
      endcase
      if (noisy)
         {ev.func, ev.btn3_down, ev.btn3_up, ev.btn4_down, ev.btn4_up} = 6'($urandom);
      ev.now_ticks = 17'(stamp_now);
      if (stamp_now < 31072 && $urandom_range(0, 99) < 10)
         ev.now_ticks = 17'(stamp_now + TICK_WRAP);
      return ev;
   endfunction

   task automatic add_row(input logic [1:0] func, input logic [3:0] btns,
                          input int unsigned knob, input int unsigned now,
                          input bit typed, input rsp_type want);
      dir_row_type row;
      row.ev.func = func;
      {row.ev.btn3_down, row.ev.btn3_up, row.ev.btn4_down, row.ev.btn4_up} = btns;
      row.ev.knob_value = 10'(knob);
      row.ev.now_ticks  = 17'(now);
      row.typed = typed;
      row.want  = want;
      directed_events.push_back(row);
   endtask

   // Called right after a rising edge; returns at the edge that accepts the request.
   task automatic send_event(input req_type ev);
      while (!calm && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic drain_snapshots();
      req_valid <= 1'b0;
      while (snapshot_q.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_long_press(input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      lp_ticks = value;
   endtask

   task automatic check_field(input string fname, input int unsigned got,
                              input int unsigned want);
      if (got != want) begin
         if (mismatches < 10)
            $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (snapshot_q.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: response with no request outstanding", $time);
            mismatches++;
         end else begin
            want = snapshot_q.pop_front();
            check_field("oven_phase", rsp_data.oven_phase, want.oven_phase);
            check_field("mode", rsp_data.mode, want.mode);
            check_field("editing_temp", rsp_data.editing_temp, want.editing_temp);
            check_field("set_seconds", rsp_data.set_seconds, want.set_seconds);
            check_field("left_seconds", rsp_data.left_seconds, want.left_seconds);
            check_field("temperature", rsp_data.temperature, want.temperature);
            check_field("led_bar", rsp_data.led_bar, want.led_bar);
            check_field("display_inverted", rsp_data.display_inverted,
                        want.display_inverted);
         end
      end
      rsp_stall <= !reset && !calm && ($urandom_range(0, 99) < 26);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("oven_control_fsm_top_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned lp_plan [5];
      int unsigned n;
      rsp_type     want;
      req_type     ev;

      lp_plan = '{2, 0, 255, 1, 0};
      lp_plan[4] = $urandom_range(3, 12);

      add_row(FUNC_KNOB, BTN_NONE, 0, 0, 1'b1,
              '{PH_SETUP, MODE_BAKE, 1'b0, 9'd1, 9'd0, 10'd300, 8'h00, 1'b0});
      add_row(FUNC_KNOB, BTN_NONE, 1023, 1, 1'b1,
              '{PH_SETUP, MODE_BAKE, 1'b0, 9'd256, 9'd0, 10'd300, 8'h00, 1'b0});
      add_row(FUNC_BUTTON, BTN_3D, 1023, 10, 1'b1,
              '{PH_SELECT, MODE_BAKE, 1'b0, 9'd256, 9'd0, 10'd300, 8'h00, 1'b0});
      add_row(FUNC_BUTTON, BTN_3U, 1023, 20, 1'b1,
              '{PH_SETUP, MODE_BAKE, 1'b1, 9'd256, 9'd0, 10'd300, 8'h00, 1'b0});
      add_row(FUNC_KNOB, BTN_NONE, 1023, 21, 1'b1,
              '{PH_SETUP, MODE_BAKE, 1'b1, 9'd256, 9'd0, 10'd555, 8'h00, 1'b0});
      add_row(FUNC_KNOB, BTN_NONE, 0, 131071, 1'b1,
              '{PH_SETUP, MODE_BAKE, 1'b1, 9'd256, 9'd0, 10'd300, 8'h00, 1'b0});
      add_row(FUNC_BUTTON, BTN_3D, 0, 99999, 1'b1,
              '{PH_SELECT, MODE_BAKE, 1'b1, 9'd256, 9'd0, 10'd300, 8'h00, 1'b0});
      add_row(FUNC_BUTTON, BTN_3U, 0, 0, 1'b1,
              '{PH_SETUP, MODE_TOAST, 1'b0, 9'd256, 9'd0, 10'd300, 8'h00, 1'b0});
      add_row(FUNC_BUTTON, BTN_3D, 77, 100005, 1'b0, '0);
      add_row(FUNC_BUTTON, BTN_3U, 77, 6, 1'b0, '0);
      add_row(FUNC_KNOB, BTN_NONE, 600, 7, 1'b0, '0);
      add_row(FUNC_BUTTON, BTN_3D | BTN_4D, 77, 9, 1'b0, '0);
      add_row(FUNC_SECOND, BTN_NONE, 77, 10, 1'b0, '0);
      add_row(FUNC_KNOB, BTN_NONE, 1023, 11, 1'b0, '0);
      add_row(FUNC_BUTTON, BTN_4D, 77, 12, 1'b0, '0);
      add_row(FUNC_KNOB, BTN_NONE, 77, 13, 1'b0, '0);
      add_row(FUNC_BUTTON, BTN_4U, 77, 13, 1'b0, '0);
      add_row(FUNC_BUTTON, BTN_4D, 77, 20, 1'b0, '0);
      add_row(FUNC_BLINK, BTN_NONE, 77, 30, 1'b0, '0);
      add_row(FUNC_KNOB, BTN_NONE, 0, 31, 1'b0, '0);
      add_row(FUNC_BUTTON, BTN_4D, 0, 32, 1'b0, '0);
      add_row(FUNC_SECOND, BTN_NONE, 0, 33, 1'b0, '0);
      add_row(FUNC_BUTTON, BTN_4D, 0, 34, 1'b0, '0);
      add_row(FUNC_SECOND, BTN_NONE, 0, 35, 1'b0, '0);
      add_row(FUNC_BLINK, BTN_NONE, 0, 36, 1'b0, '0);
      add_row(FUNC_BUTTON, BTN_3U, 0, 37, 1'b0, '0);
      add_row(FUNC_BUTTON, BTN_4D, 0, 38, 1'b0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_events[i]) begin
         want = oven_step(directed_events[i].ev);
         if (directed_events[i].typed)
            want = directed_events[i].want;
         snapshot_q.push_back(want);
         send_event(directed_events[i].ev);
      end

      stamp_now = 40;
      for (int step = 0; step < 5; step++) begin
         if (step > 0) begin
            drain_snapshots();
            write_long_press(8'(lp_plan[step]));
         end
         calm = (step == 2);
         n = 0;
         while (n < EVENTS_PER_STEP) begin
            ev = next_event();
            snapshot_q.push_back(oven_step(ev));
            send_event(ev);
            n++;
            if (step == 0 && n == EVENTS_PER_STEP / 2)
               drain_snapshots();
         end
      end

      drain_snapshots();
      if (mismatches == 0)
         $display("oven_control_fsm_top_tb: done, clean");
      else
         $display("oven_control_fsm_top_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
src/ocf_pkg.sv
src/oven_control_fsm_top.sv
verif/oven_control_fsm_top_tb.sv
